>>> design/top_k_sum_multiset_unit_macros.svh
// Assertion macros for the top-k sum unit.
`ifndef TOP_K_SUM_MULTISET_UNIT_MACROS_SVH
`define TOP_K_SUM_MULTISET_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TKS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define TKS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> design/tks_pkg.sv
`default_nettype none
package tks_pkg;
	localparam int unsigned NumSlotsDef = 1024;
	localparam int unsigned CountW = 16;
	localparam int unsigned ValueW = 31;
	localparam int unsigned SumW = 48;
	localparam int unsigned OutW = 47;
	localparam logic [CountW-1:0] CountLimit = '1;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_OVERFLOW = 2'd2
	} stat_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_LEAF_RD,
		S_LEAF_WT,
		S_DECIDE,
		S_UP_RD,
		S_UP_WT,
		S_UP_WR,
		S_DN_RD,
		S_DN_WT,
		S_DN_STEP,
		S_LAST,
		S_FINISH,
		S_OUT
	} fsm_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic init_wr;   // zero one memory address after reset
		logic capture;   // latch input beat
		logic leaf_rd;   // read leaf and root
		logic decide;    // evaluate update legality
		logic up_rd;     // read siblings of current path node
		logic up_wr;     // write parent node
		logic up_step;   // climb one level
		logic dn_init;   // start descent at root
		logic dn_rd;     // read right child
		logic dn_step;   // take one descent step
		logic last;      // read leaf value for the remainder product
		logic finish;    // form outputs and update maximum
	} tks_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic init_done;
		logic clear_cmd;
		logic do_update;
		logic at_root;
		logic at_leaf;
		logic enough;
	} tks_stat_t;
endpackage
`default_nettype wire

>>> design/tks_ctrl.sv
`default_nettype none
module tks_ctrl
	import tks_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_fire,
	input  wire logic      out_free,
	input  wire tks_stat_t st,
	output logic           busy,
	output logic           out_load,
	output tks_cmd_t       cmd
);
	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: if (st.init_done) state_d = S_IDLE;
			S_IDLE: if (in_fire) state_d = S_LEAF_RD;
			S_LEAF_RD: state_d = S_LEAF_WT;
			S_LEAF_WT: state_d = S_DECIDE;
			S_DECIDE: begin
				if (st.clear_cmd || !st.do_update) state_d = S_DN_RD;
				else if (st.at_root) state_d = S_DN_RD;
				else state_d = S_UP_RD;
			end
			S_UP_RD: state_d = S_UP_WT;
			S_UP_WT: state_d = S_UP_WR;
			S_UP_WR: state_d = st.at_root ? S_DN_RD : S_UP_RD;
			S_DN_RD: begin
				if (!st.enough || st.at_leaf) state_d = S_LAST;
				else state_d = S_DN_WT;
			end
			S_DN_WT: state_d = S_DN_STEP;
			S_DN_STEP: state_d = st.at_leaf ? S_LAST : S_DN_WT;
			S_LAST: state_d = S_FINISH;
			S_FINISH: state_d = S_OUT;
			S_OUT: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		out_load = 1'b0;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_INIT: cmd.init_wr = 1'b1;
			S_IDLE: cmd.capture = in_fire;
			S_LEAF_RD: cmd.leaf_rd = 1'b1;
			S_DECIDE: cmd.decide = 1'b1;
			S_UP_RD: cmd.up_rd = 1'b1;
			S_UP_WR: begin
				cmd.up_wr = 1'b1;
				cmd.up_step = 1'b1;
			end
			S_DN_RD: begin
				cmd.dn_init = 1'b1;
				cmd.dn_rd = 1'b1;
			end
			S_DN_STEP: begin
				cmd.dn_step = 1'b1;
				cmd.dn_rd = 1'b1;
			end
			S_LAST: cmd.last = 1'b1;
			S_FINISH: cmd.finish = 1'b1;
			S_OUT: out_load = out_free;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> design/tks_datapath.sv
`default_nettype none
module tks_datapath
	import tks_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = NumSlotsDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tks_cmd_t          cmd,
	input  wire logic [CountW-1:0] top_count,
	input  wire logic [1:0]        in_command,
	input  wire logic [15:0]       in_slot,
	input  wire logic [ValueW-1:0] in_value,
	input  wire logic [CountW-1:0] in_count,
	output tks_stat_t              st,
	output logic [OutW-1:0]        top_sum,
	output logic                   enough_held,
	output logic [OutW-1:0]        best_sum,
	output logic [1:0]             status
);
	// Perfect binary tree over the padded slot range; node 1 is the root.
	localparam int unsigned LW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int unsigned Leaves = 1 << LW;
	localparam int unsigned NW = LW + 1;
	localparam int unsigned Nodes = 2 * Leaves;
	localparam int unsigned ProdW = ValueW + CountW;

	logic [CountW-1:0] cnt_mem [Nodes];
	logic [SumW-1:0]   sum_mem [Nodes];
	logic [ValueW-1:0] val_mem [Leaves];
	// After reset every address is zeroed, one per cycle.
	logic [NW-1:0]     clr_q;

	cmd_t              cmd_q;
	logic              slot_ok_q;
	logic [LW-1:0]     slot_q;
	logic [ValueW-1:0] value_q;
	logic [CountW-1:0] count_q;
	logic [NW-1:0]     node_q;
	logic [LW:0]       level_q;
	logic [1:0]        status_q;

	// Memory read ports: port A and port B, registered.
	logic [NW-1:0]     ra_addr, rb_addr;
	logic              ra_en, rb_en;
	logic [CountW-1:0] ca_q, cb_q;
	logic [SumW-1:0]   sa_q, sb_q;
	logic [ValueW-1:0] vr_q;

	logic [CountW-1:0] total_q, old_q;
	logic [CountW-1:0] want_q;
	logic [SumW-1:0]   acc_q;
	logic              enough_q;
	logic [SumW-1:0]   best_q;
	logic [OutW-1:0]   top_q;
	logic [CountW-1:0] cnt_mem_root;

	logic [CountW-1:0] rd_ca, rd_cb;
	logic [SumW-1:0]   rd_sa, rd_sb;
	logic [NW-1:0]     leaf_node;
	logic [NW-1:0]     wr_addr;
	logic [CountW-1:0] wr_cnt;
	logic [SumW-1:0]   wr_sum;
	logic              wr_en;

	logic              legal;
	logic              update_d_load;
	logic [1:0]        stat_d;
	logic [CountW-1:0] nc;
	logic [CountW:0]   after_load;
	logic [ValueW-1:0] leaf_v, wr_val;
	logic [ProdW-1:0]  leaf_prod, prod_w;
	logic [SumW-1:0]   top_w, top_ext;

	assign leaf_node = {1'b1, slot_q};
	assign rd_ca = ca_q;
	assign rd_cb = cb_q;
	assign rd_sa = sa_q;
	assign rd_sb = sb_q;

	always_comb begin
		ra_en = 1'b0;
		rb_en = 1'b0;
		ra_addr = leaf_node;
		rb_addr = NW'(1);
		if (cmd.leaf_rd) begin
			ra_en = 1'b1;
			rb_en = 1'b1;
		end else if (cmd.up_rd) begin
			ra_en = 1'b1;
			rb_en = 1'b1;
			ra_addr = {node_q[NW-1:1], 1'b0};
			rb_addr = {node_q[NW-1:1], 1'b1};
		end else if (cmd.dn_rd) begin
			rb_en = 1'b1;
			// Right child of the node that this step moves to.
			if (cmd.dn_init) rb_addr = NW'(3);
			else if (want_q > rd_cb) rb_addr = NW'({node_q, 2'b01});
			else rb_addr = NW'({node_q, 2'b11});
		end
	end

	always_ff @(posedge clk) begin
		if (ra_en) begin
			ca_q <= cnt_mem[ra_addr];
			sa_q <= sum_mem[ra_addr];
		end
		if (rb_en) begin
			cb_q <= cnt_mem[rb_addr];
			sb_q <= sum_mem[rb_addr];
		end
		if (cmd.leaf_rd || cmd.last) vr_q <= val_mem[cmd.last ? node_q[LW-1:0] : slot_q];
		if (wr_en) begin
			cnt_mem[wr_addr] <= wr_cnt;
			sum_mem[wr_addr] <= wr_sum;
		end
		if (cmd.init_wr) val_mem[clr_q[LW-1:0]] <= '0;
		else if (cmd.decide && update_d_load) val_mem[slot_q] <= value_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.init_wr) clr_q <= clr_q + 1'b1;
	end

	// Legality of the update from the leaf and root counts.
	assign leaf_v = vr_q;
	always_comb begin
		legal = 1'b0;
		stat_d = ST_OK;
		nc = old_q;
		after_load = {1'b0, total_q} - {1'b0, old_q} + {1'b0, count_q};
		update_d_load = 1'b0;
		if (slot_ok_q) begin
			case (cmd_q)
				CMD_LOAD: begin
					if (after_load > {1'b0, CountLimit}) stat_d = ST_OVERFLOW;
					else begin
						legal = 1'b1;
						nc = count_q;
						update_d_load = cmd.decide;
					end
				end
				CMD_INSERT: begin
					if (total_q >= CountLimit) stat_d = ST_OVERFLOW;
					else begin
						legal = 1'b1;
						nc = old_q + 1'b1;
					end
				end
				CMD_REMOVE: begin
					if (old_q == '0) stat_d = ST_EMPTY;
					else begin
						legal = 1'b1;
						nc = old_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign wr_val = (cmd_q == CMD_LOAD) ? value_q : leaf_v;
	assign leaf_prod = ProdW'(nc) * ProdW'(wr_val);

	// Zeroing writes during init; leaf write at decide; parent write while climbing.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = leaf_node;
		wr_cnt = nc;
		wr_sum = SumW'(leaf_prod);
		if (cmd.init_wr) begin
			wr_en = 1'b1;
			wr_addr = clr_q;
			wr_cnt = '0;
			wr_sum = '0;
		end else if (cmd.decide) wr_en = legal;
		else if (cmd.up_wr) begin
			wr_en = 1'b1;
			wr_addr = node_q >> 1;
			wr_cnt = rd_ca + rd_cb;
			wr_sum = rd_sa + rd_sb;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= cmd_t'(in_command);
			slot_ok_q <= ({16'd0, in_slot} < 32'(NUM_SLOTS));
			slot_q <= in_slot[LW-1:0];
			value_q <= in_value;
			count_q <= in_count;
		end
		if (cmd.decide) begin
			status_q <= stat_d;
			node_q <= leaf_node;
		end
		if (cmd.up_step) node_q <= node_q >> 1;
		if (cmd.dn_init) begin
			node_q <= NW'(1);
			level_q <= '0;
			want_q <= top_count;
			acc_q <= '0;
			enough_q <= cnt_mem_root >= top_count;
		end else if (cmd.dn_step) begin
			level_q <= level_q + 1'b1;
			if (want_q <= rd_cb) node_q <= {node_q[NW-2:0], 1'b1};
			else begin
				node_q <= {node_q[NW-2:0], 1'b0};
				acc_q <= acc_q + rd_sb;
				want_q <= want_q - rd_cb;
			end
		end
		if (cmd.finish) top_q <= enough_q ? top_w[OutW-1:0] : '0;
	end

	// Root count kept in a register, updated with every root write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_mem_root <= '0;
		else if (wr_en && wr_addr == NW'(1)) cnt_mem_root <= wr_cnt;
	end

	always_ff @(posedge clk) begin
		if (cmd.leaf_rd) total_q <= cnt_mem_root;
	end
	always_comb old_q = rd_ca;

	// Final leaf contribution: value times remaining want.
	assign prod_w = ProdW'(leaf_v) * ProdW'(want_q);
	assign top_w = acc_q + SumW'(prod_w);
	assign top_ext = SumW'(top_w[OutW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) best_q <= '0;
		else if (cmd.finish) begin
			if (cmd_q == CMD_CLEAR) best_q <= enough_q ? top_ext : '0;
			else if (enough_q && top_ext > best_q) best_q <= top_ext;
		end
	end

	assign st.init_done = &clr_q;
	assign st.clear_cmd = (cmd_q == CMD_CLEAR);
	assign st.do_update = legal;
	assign st.at_root = cmd.decide ? (leaf_node == NW'(1)) : ((node_q >> 1) == NW'(1));
	assign st.at_leaf = cmd.dn_init ? (LW == 0) : (level_q == (LW[LW:0] - 1'b1));
	assign st.enough = cnt_mem_root >= top_count;

	assign top_sum = top_q;
	assign enough_held = enough_q;
	assign best_sum = best_q[OutW-1:0];
	assign status = status_q;
endmodule
`default_nettype wire

>>> design/top_k_sum_multiset_unit.sv
// One item at a time: an updating beat rewrites the tree path from the leaf up to the
// root before the descent; other beats run the descent only. The next beat is taken
// the cycle after the result is loaded, and loading waits for any output stall.
// Reset sets top_count to 1 and clears the running maximum, then a clearing pass
// zeroes all memories with s_tready low.
`default_nettype none
`include "top_k_sum_multiset_unit_macros.svh"
module top_k_sum_multiset_unit
	import tks_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = NumSlotsDef
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [15:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [1:0]   s_tuser,  // command
	// slot_index[9:0], slot_value[40:10], slot_count[56:41], zero fill
	input  wire logic [63:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [1:0]        m_tuser,  // status
	// top_sum[46:0], enough_held[47], best_sum[94:48], zero fill
	output logic [95:0]       m_tdata
);
	logic [CountW-1:0] top_count_q;
	tks_cmd_t  cmd;
	tks_stat_t st;
	logic busy, out_load, in_fire;
	logic [OutW-1:0] top_sum, best_sum;
	logic enough;
	logic [1:0] status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) top_count_q <= 16'd1;
		else if (cfg_we) top_count_q <= cfg_wdata;
	end

	assign s_tready = !busy;
	assign in_fire = s_tvalid && s_tready;

	tks_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_free(!m_tvalid || m_tready), .st(st),
		.busy(busy), .out_load(out_load), .cmd(cmd)
	);

	tks_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .top_count(top_count_q),
		.in_command(s_tuser), .in_slot({6'd0, s_tdata[9:0]}),
		.in_value(s_tdata[40:10]), .in_count(s_tdata[56:41]),
		.st(st), .top_sum(top_sum), .enough_held(enough),
		.best_sum(best_sum), .status(status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (out_load) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {1'b0, best_sum, enough, top_sum};
			m_tuser <= status;
		end
	end

	`TKS_ASSERT_IMPL(a_no_accept_busy, busy, !s_tready, "input taken while busy")
	`TKS_ASSERT_NEXT(a_out_held, m_tvalid && !m_tready, m_tvalid, "result dropped")
	`TKS_ASSERT_IMPL(a_best_ge_top, m_tvalid, m_tdata[94:48] >= m_tdata[46:0], "best below sum")
endmodule
`default_nettype wire

>>> tb/top_k_sum_checker.sv
`default_nettype none
module top_k_sum_checker
	import tks_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [1:0]  s_tuser,
	input  wire logic [63:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [1:0]  m_tuser,
	input  wire logic [95:0] m_tdata,
	output int               fail_count,
	output int               pending_count,
	output int               result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned Slots = 1024;

	typedef struct packed {
		logic [46:0] top_sum;
		logic        enough_held;
		logic [46:0] best_sum;
		stat_t       status;
	} result_t;

	logic [15:0] want_count;
	logic [30:0] slot_val[Slots];
	logic [15:0] slot_cnt[Slots];
	logic [47:0] best_seen;
	result_t     expected_q[$];

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp);
		$display("mismatch at result %0d: %s got %0h expected %0h",
			result_count, what, got, exp);
		fail_count++;
	endtask

	// Sums want_count items walking from the highest slot down,
	// which is what the tree descent yields.
	function automatic result_t predict_result(input logic [1:0] cmd,
			input logic [9:0] idx, input logic [30:0] val, input logic [15:0] cnt);
		result_t r;
		int unsigned total;
		int unsigned left;
		logic [63:0] acc;
		total = 0;
		acc = 0;
		r.status = ST_OK;
		foreach (slot_cnt[i]) total += slot_cnt[i];
		case (cmd)
			CMD_CLEAR: begin
				best_seen = 0;
			end
			CMD_LOAD: begin
				if (total - slot_cnt[idx] + cnt > 65535) begin
					r.status = ST_OVERFLOW;
				end else begin
					total = total - slot_cnt[idx] + cnt;
					slot_val[idx] = val;
					slot_cnt[idx] = cnt;
				end
			end
			CMD_INSERT: begin
				if (total >= 65535) begin
					r.status = ST_OVERFLOW;
				end else begin
					slot_cnt[idx]++;
					total++;
				end
			end
			default: begin
				if (slot_cnt[idx] == 0) begin
					r.status = ST_EMPTY;
				end else begin
					slot_cnt[idx]--;
					total--;
				end
			end
		endcase
		r.enough_held = total >= want_count;
		if (r.enough_held) begin
			left = want_count;
			for (int i = Slots - 1; i >= 0 && left > 0; i--) begin
				if (slot_cnt[i] >= left) begin
					acc += 64'(slot_val[i]) * left;
					left = 0;
				end else begin
					acc += 64'(slot_val[i]) * slot_cnt[i];
					left -= slot_cnt[i];
				end
			end
		end
		r.top_sum = acc[46:0];
		if ({1'b0, r.top_sum} > best_seen) best_seen = {1'b0, r.top_sum};
		r.best_sum = best_seen[46:0];
		return r;
	endfunction

	assign pending_count = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		result_t exp;
		result_t got;
		if (!arst_n) begin
			want_count <= 16'd1;
			best_seen = 0;
			foreach (slot_cnt[i]) begin
				slot_cnt[i] = 0;
				slot_val[i] = 0;
			end
			expected_q.delete();
			fail_count = 0;
			result_count <= 0;
		end else begin
			if (cfg_we) want_count <= cfg_wdata;
			if (s_tvalid && s_tready)
				expected_q.push_back(predict_result(s_tuser, s_tdata[9:0],
					s_tdata[40:10], s_tdata[56:41]));
			if (m_tvalid && m_tready) begin
				got.top_sum = m_tdata[46:0];
				got.enough_held = m_tdata[47];
				got.best_sum = m_tdata[94:48];
				got.status = stat_t'(m_tuser);
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected beat", 64'd0, 64'd0);
				end else begin
					exp = expected_q.pop_front();
					if (got.top_sum !== exp.top_sum)
						report_mismatch("top_sum", 64'(got.top_sum), 64'(exp.top_sum));
					if (got.enough_held !== exp.enough_held)
						report_mismatch("enough_held", 64'(got.enough_held),
							64'(exp.enough_held));
					if (got.best_sum !== exp.best_sum)
						report_mismatch("best_sum", 64'(got.best_sum), 64'(exp.best_sum));
					if (got.status !== exp.status)
						report_mismatch("status", 64'(got.status), 64'(exp.status));
				end
				result_count <= result_count + 1;
			end
		end
	end
endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench
	import tks_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = '0;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [1:0]  m_tuser;
	logic [95:0] m_tdata;
	int          fail_count;
	int          pending_count;
	int          result_count;
	int          idle_cycles = 0;
	int          items_sent = 0;
	bit          stall_free = 1'b0;

	always #4 clk = ~clk;

	top_k_sum_multiset_unit i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
	);

	top_k_sum_checker i_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending_count(pending_count),
		.result_count(result_count)
	);

	function automatic int pick_gap();
		if (stall_free) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	// Result side stalls at random, independent of the input side.
	always @(negedge clk) begin
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			m_tready <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("watchdog expired with %0d results outstanding", pending_count);
			$display("** top_k_sum_multiset_unit: FAILED **");
			$finish;
		end
	end

	// The valid line stays high into the next item unless a gap follows.
	task automatic send_item(input cmd_t cmd, input logic [9:0] idx,
			input logic [30:0] val, input logic [15:0] cnt);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {7'd0, cnt, val, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic write_top_count(input logic [15:0] k);
		s_tvalid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= k;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Values mostly ascend with slot so the sum is the true top-k sum.
	task automatic random_phase(input int n, input int span);
		int unsigned r;
		logic [9:0] idx;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			idx = (span >= 1023) ? 10'($urandom) : 10'($urandom_range(0, span));
			if (r < 20)
				send_item(CMD_LOAD, idx,
					(r < 3) ? 31'($urandom) : 31'({idx, 21'($urandom)}),
					(r < 2) ? 16'($urandom) : 16'($urandom_range(0, 40)));
			else if (r < 60)
				send_item(CMD_INSERT, idx, 31'($urandom), 16'($urandom));
			else if (r < 95)
				send_item(CMD_REMOVE, idx, 31'($urandom), 16'($urandom));
			else
				send_item(CMD_CLEAR, idx, 31'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty removes, extremes of every field, overflow of the total.
		send_item(CMD_REMOVE, 10'd0, '0, '0);
		send_item(CMD_INSERT, 10'd1023, 31'h7FFF_FFFF, 16'hFFFF);
		send_item(CMD_LOAD, 10'd1023, 31'h7FFF_FFFF, 16'd3);
		send_item(CMD_LOAD, 10'd0, 31'd0, 16'd2);
		send_item(CMD_LOAD, 10'd512, 31'h5555_5555, 16'hFFF0);
		send_item(CMD_INSERT, 10'd0, '0, '0);
		send_item(CMD_LOAD, 10'd511, 31'h2AAA_AAAA, 16'd100);
		send_item(CMD_LOAD, 10'd511, 31'h2AAA_AAAA, 16'd10);
		send_item(CMD_INSERT, 10'd511, '0, '0);
		send_item(CMD_INSERT, 10'd511, '0, '0);
		send_item(CMD_REMOVE, 10'd1023, '0, '0);
		send_item(CMD_CLEAR, '0, '0, '0);
		send_item(CMD_LOAD, 10'd512, 31'h5555_5555, 16'd0);
		send_item(CMD_CLEAR, '0, '0, '0);
		send_item(CMD_LOAD, 10'd1023, 31'd7, 16'hFFFF);
		send_item(CMD_LOAD, 10'd1023, 31'd7, 16'd1);
		write_top_count(16'hFFFF);
		send_item(CMD_INSERT, 10'd700, '0, '0);
		send_item(CMD_LOAD, 10'd700, 31'd9, 16'hFFF0);
		write_top_count(16'd0);
		send_item(CMD_REMOVE, 10'd3, '0, '0);
		send_item(CMD_CLEAR, '0, '0, '0);

		write_top_count(16'd1);
		random_phase(250, 15);
		write_top_count(16'd5);
		random_phase(300, 1023);
		stall_free = 1'b1;
		write_top_count(16'($urandom_range(2, 60)));
		random_phase(200, 63);
		stall_free = 1'b0;
		write_top_count(16'($urandom_range(100, 2000)));
		random_phase(300, 1023);
		write_top_count(16'hFFFF);
		random_phase(150, 31);
		write_top_count(16'd0);
		random_phase(100, 1023);
		write_top_count(16'($urandom));
		random_phase(250, 1023);

		s_tvalid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		$display("%0d items sent, %0d results checked, top_count from 0 to 65535,",
			items_sent, result_count);
		$display("loads, inserts, removes, clears, empty and overflow cases covered.");
		if (fail_count == 0)
			$display("** top_k_sum_multiset_unit: PASSED **");
		else
			$display("** top_k_sum_multiset_unit: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
+incdir+design
design/tks_pkg.sv
design/tks_ctrl.sv
design/tks_datapath.sv
design/top_k_sum_multiset_unit.sv
tb/top_k_sum_checker.sv
tb/testbench.sv
